FILE: rtl/rbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg - shared types and constants of the rail bus message deframer
// Header codes, sub-codes, event kinds and the structs passed between modules.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int CAPTURE_BYTES_DEF = 6;

  // header byte codes
  localparam logic [7:0] HDR_CLASS_MASK = 8'hE0;
  localparam logic [7:0] HDR_INFO       = 8'h00;
  localparam logic [7:0] HDR_SENSOR     = 8'h4B;
  localparam logic [7:0] HDR_VEHICLE    = 8'h40;
  localparam logic [7:0] HDR_LOGOUT     = 8'h60;

  // sub-codes carried in packet byte 2
  localparam logic [7:0] SUB_SYS_STATUS = 8'h01;
  localparam logic [7:0] SUB_NOT_IN_USE = 8'h08;
  localparam logic [7:0] SUB_IN_USE     = 8'h04;

  // power field of the system status packet and state mask of the sensor packet
  localparam logic [7:0] PWR_MASK       = 8'h03;
  localparam logic [7:0] PWR_ON         = 8'h02;
  localparam logic [7:0] SENSOR_ST_MASK = 8'h01;

  typedef enum logic [2:0] {
    EV_SYS_STATUS  = 3'd0,
    EV_SENSOR      = 3'd1,
    EV_LOGGED_OUT  = 3'd2,
    EV_NOT_IN_USE  = 3'd3,
    EV_IN_USE      = 3'd4,
    EV_UNHANDLED   = 3'd5
  } event_kind_t;

  // header and packet bytes 2..6 as seen when the packet completes, bytes 2..6 zero past its end
  typedef struct packed {
    logic [7:0] head;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
  } pkt_bytes_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] address;
    logic        state_bit;
    logic [7:0]  device_id;
    logic [7:0]  header_code;
  } event_t;

endpackage

FILE: rtl/rbd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_in_if - receive byte channel
// Valid/ready channel carrying one serial byte per request.
// ----------------------------------------------------------------------------
interface rbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/rbd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_out_if - decoded event channel
// Valid/ready channel carrying one decoded packet event per request.
// ----------------------------------------------------------------------------
interface rbd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [15:0] address;
  logic        state_bit;
  logic [7:0]  device_id;
  logic [7:0]  header_code;

  modport source (output valid, output event_kind, output address, output state_bit,
                  output device_id, output header_code, input ready);
  modport sink   (input valid, input event_kind, input address, input state_bit,
                  input device_id, input header_code, output ready);
endinterface

FILE: rtl/rbd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_decode - packet event decoder
// Maps the header and packet bytes 2..6 of a completed packet to one event.
// ----------------------------------------------------------------------------
module rbd_decode (
  input  rbd_pkg::pkt_bytes_t pkt,
  output rbd_pkg::event_t     ev
);

  always_comb begin
    ev             = '0;
    ev.event_kind  = rbd_pkg::EV_UNHANDLED;
    ev.header_code = pkt.head;
    case (pkt.head)
      rbd_pkg::HDR_INFO: begin
        if (pkt.b2 == rbd_pkg::SUB_SYS_STATUS) begin
          ev.event_kind = rbd_pkg::EV_SYS_STATUS;
          ev.state_bit  = ((pkt.b3 & rbd_pkg::PWR_MASK) == rbd_pkg::PWR_ON);
        end
      end
      rbd_pkg::HDR_SENSOR: begin
        ev.event_kind = rbd_pkg::EV_SENSOR;
        ev.state_bit  = |(pkt.b3 & rbd_pkg::SENSOR_ST_MASK);
        ev.address    = {2'b00, pkt.b2, 6'b0} + {10'b0, pkt.b3[7:2]};
      end
      rbd_pkg::HDR_LOGOUT: begin
        ev.event_kind = rbd_pkg::EV_LOGGED_OUT;
        ev.address    = {pkt.b3, pkt.b4};
      end
      rbd_pkg::HDR_VEHICLE: begin
        if (pkt.b2 == rbd_pkg::SUB_NOT_IN_USE) begin
          ev.event_kind = rbd_pkg::EV_NOT_IN_USE;
          ev.address    = {pkt.b3, pkt.b4};
        end else if (pkt.b2 == rbd_pkg::SUB_IN_USE) begin
          ev.event_kind = rbd_pkg::EV_IN_USE;
          ev.address    = {pkt.b4, pkt.b5};
          ev.device_id  = pkt.b6;
        end
      end
      default: begin
        ev.event_kind = rbd_pkg::EV_UNHANDLED;
      end
    endcase
  end

endmodule

FILE: rtl/rail_bus_message_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rail_bus_message_deframer_core - serial byte stream to packet events
// Frames received bytes into info and command packets and decodes each
// completed packet into one event.
//
// Usage:
//   in_ch  carries one received serial byte per request (rx_byte).
//   out_ch carries one decoded event per completed packet.
//   One byte is taken per cycle while in_ch.ready is high. The framing state,
//   the capture bytes and the event decoder update in the cycle a byte is
//   taken; the event of a packet's last byte is loaded into a result
//   register. Bytes that complete no packet produce nothing.
//   An output register plus a one-entry skid register part the two sides:
//   bytes keep flowing while an event waits, and in_ch.ready drops only
//   once an event sits in the skid register, i.e. two events are waiting.
//   Reset (rst, synchronous) returns to waiting for a header and empties
//   both result registers; capture bytes are not cleared since every byte
//   read is written earlier in the same packet.
// ----------------------------------------------------------------------------
module rail_bus_message_deframer_core #(
  parameter int CAPTURE_BYTES = rbd_pkg::CAPTURE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rbd_in_if.sink        in_ch,
  rbd_out_if.source     out_ch
);

  localparam int IDX_W = $clog2(CAPTURE_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_INFOHDR = 2'd1,
    PH_BODY    = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  head_byte;
  logic [8:0]  byte_count, byte_count_next;
  logic [8:0]  total_length, total_length_next;
  logic [7:0]  capture [CAPTURE_BYTES];

  logic        in_take;
  logic        emit;
  logic [8:0]  wr_pos;
  logic        wr_en;

  rbd_pkg::pkt_bytes_t pkt;
  rbd_pkg::event_t     ev_new;
  rbd_pkg::event_t     out_ev, skid_ev;
  logic                out_valid, skid_valid;
  logic                out_pop;

  // Accept bytes until the skid register holds a waiting event.
  assign in_ch.ready = !skid_valid;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Capture slot of the current byte: packet position 1 maps to slot 0.
  assign wr_pos = byte_count - 9'd1;
  assign wr_en  = in_take && (phase != PH_IDLE) && (byte_count != 9'd0)
                  && (wr_pos < 9'(CAPTURE_BYTES));

  // Framing update for one byte.
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    total_length_next = total_length;
    emit              = 1'b0;
    case (phase)
      PH_IDLE: begin
        byte_count_next = 9'd1;
        if ((in_ch.rx_byte & rbd_pkg::HDR_CLASS_MASK) == 8'h00) begin
          total_length_next = 9'd3;
          phase_next        = PH_INFOHDR;
        end else begin
          total_length_next = {6'b0, in_ch.rx_byte[7:5]} + 9'd2;
          phase_next        = PH_BODY;
        end
      end
      PH_INFOHDR, PH_BODY: begin
        byte_count_next = byte_count + 9'd1;
        if (phase == PH_INFOHDR && byte_count == 9'd2) begin
          total_length_next = {1'b0, in_ch.rx_byte} + 9'd3;
          phase_next        = PH_BODY;
        end
        if (byte_count_next >= total_length_next) begin
          emit            = 1'b1;
          phase_next      = PH_IDLE;
          byte_count_next = 9'd0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Packet bytes for the decoder: take the arriving byte at its own position,
  // the captured byte elsewhere, zero past the packet end.
  function automatic logic [7:0] pick(input logic [8:0] p, input logic [7:0] cap,
                                      input logic [8:0] cnt, input logic [8:0] tot,
                                      input logic [7:0] rx);
    logic [7:0] v;
    v = (cnt == p) ? rx : cap;
    return (p < tot) ? v : 8'h00;
  endfunction

  always_comb begin
    pkt.head = head_byte;
    pkt.b2   = pick(9'd2, capture[1], byte_count, total_length_next, in_ch.rx_byte);
    pkt.b3   = pick(9'd3, capture[2], byte_count, total_length_next, in_ch.rx_byte);
    pkt.b4   = pick(9'd4, capture[3], byte_count, total_length_next, in_ch.rx_byte);
    pkt.b5   = pick(9'd5, capture[4], byte_count, total_length_next, in_ch.rx_byte);
    pkt.b6   = pick(9'd6, capture[5], byte_count, total_length_next, in_ch.rx_byte);
  end

  rbd_decode u_decode (
    .pkt (pkt),
    .ev  (ev_new)
  );

  // Framing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      head_byte    <= 8'h00;
      byte_count   <= 9'd0;
      total_length <= 9'd0;
    end else if (in_take) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      total_length <= total_length_next;
      if (phase == PH_IDLE) begin
        head_byte <= in_ch.rx_byte;
      end
    end
  end

  // Capture bytes, no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      capture[wr_pos[IDX_W-1:0]] <= in_ch.rx_byte;
    end
  end

  // Result registers: output stage plus skid stage.
  assign out_pop = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_pop) begin
        if (skid_valid) begin
          out_ev     <= skid_ev;
          skid_valid <= 1'b0;
        end else if (in_take && emit) begin
          out_ev <= ev_new;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (in_take && emit) begin
        if (!out_valid) begin
          out_ev    <= ev_new;
          out_valid <= 1'b1;
        end else begin
          skid_ev    <= ev_new;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.event_kind  = out_ev.event_kind;
  assign out_ch.address     = out_ev.address;
  assign out_ch.state_bit   = out_ev.state_bit;
  assign out_ch.device_id   = out_ev.device_id;
  assign out_ch.header_code = out_ev.header_code;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the rail bus message deframer core
// Feeds received bytes through the input channel: a short table of directed
// packets, then random packet streams under four idling patterns. A local
// framing predictor tracks every accepted byte and queues the event each
// completed packet must produce; the output monitor checks events in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP_BYTES   = rbd_pkg::CAPTURE_BYTES_DEF;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int PHASE_BYTES = 340;   // random bytes per idling phase
  localparam int DRAIN_WAIT  = 8;     // cycles held after the last event
  localparam rbd_pkg::event_t NO_EVENT = '0;

  // framing phase of the predictor
  typedef enum logic [1:0] {
    FR_IDLE,      // awaiting a header
    FR_INFO_LEN,  // info packet, awaiting the length byte
    FR_BODY       // collecting the packet body
  } frame_phase_t;

  // one directed byte; ev is the typed event where typed is set
  typedef struct packed {
    logic [7:0]      rx;
    logic            typed;
    rbd_pkg::event_t ev;
  } stim_row_t;

  // Directed packets, one row per byte. The event sits on the last byte.
  localparam int N_DIRECTED = 27;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // system status, power on
    {8'h00, 1'b0, NO_EVENT}, {8'h55, 1'b0, NO_EVENT}, {8'h01, 1'b0, NO_EVENT},
    {8'h02, 1'b1, {rbd_pkg::EV_SYS_STATUS, 16'h0000, 1'b1, 8'h00, rbd_pkg::HDR_INFO}},
    // info packet of length zero completes on its third byte
    {8'h00, 1'b0, NO_EVENT}, {8'hFF, 1'b0, NO_EVENT},
    {8'h00, 1'b1, {rbd_pkg::EV_UNHANDLED, 16'h0000, 1'b0, 8'h00, rbd_pkg::HDR_INFO}},
    // sensor, all ones in address and state
    {8'h4B, 1'b0, NO_EVENT}, {8'h12, 1'b0, NO_EVENT}, {8'hFF, 1'b0, NO_EVENT},
    {8'hFF, 1'b1, {rbd_pkg::EV_SENSOR, 16'h3FFF, 1'b1, 8'h00, rbd_pkg::HDR_SENSOR}},
    // vehicle logged out
    {8'h60, 1'b0, NO_EVENT}, {8'h00, 1'b0, NO_EVENT}, {8'h00, 1'b0, NO_EVENT},
    {8'hAB, 1'b0, NO_EVENT},
    {8'hCD, 1'b1, {rbd_pkg::EV_LOGGED_OUT, 16'hABCD, 1'b0, 8'h00, rbd_pkg::HDR_LOGOUT}},
    // not in use: the low address byte lies past the packet end
    {8'h40, 1'b0, NO_EVENT}, {8'h00, 1'b0, NO_EVENT}, {8'h08, 1'b0, NO_EVENT},
    {8'h7F, 1'b1, {rbd_pkg::EV_NOT_IN_USE, 16'h7F00, 1'b0, 8'h00, rbd_pkg::HDR_VEHICLE}},
    // in use: address and device all past the packet end
    {8'h40, 1'b0, NO_EVENT}, {8'h11, 1'b0, NO_EVENT}, {8'h04, 1'b0, NO_EVENT},
    {8'h22, 1'b1, {rbd_pkg::EV_IN_USE, 16'h0000, 1'b0, 8'h00, rbd_pkg::HDR_VEHICLE}},
    // info packet with a non-zero header, left to the predictor
    {8'h1F, 1'b0, NO_EVENT}, {8'h80, 1'b0, NO_EVENT}, {8'h00, 1'b0, NO_EVENT}
  };

  logic clk = 1'b0;
  logic rst;

  rbd_in_if  in_ch ();
  rbd_out_if out_ch ();

  rail_bus_message_deframer_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  frame_phase_t fr_phase;
  logic [7:0]   fr_head;
  logic [8:0]   fr_count;
  logic [8:0]   fr_total;
  logic [7:0]   fr_cap [CAP_BYTES];

  rbd_pkg::event_t pending_events [$];  // events owed by the block, oldest first
  logic [7:0]      pkt_bytes [$];       // random packet under construction
  int         err_count  = 0;
  int         idle_count = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Packet byte at a position; reads zero past the packet end or the capture.
  function automatic logic [7:0] packet_byte(input int pos);
    if (pos == 0 || pos >= fr_total || pos > CAP_BYTES)
      return 8'h00;
    return fr_cap[pos - 1];
  endfunction

  // Decode the completed packet into its event.
  function automatic rbd_pkg::event_t decode_packet();
    rbd_pkg::event_t ev;
    ev = NO_EVENT;
    ev.event_kind  = rbd_pkg::EV_UNHANDLED;
    ev.header_code = fr_head;
    case (fr_head)
      rbd_pkg::HDR_INFO: begin
        if (packet_byte(2) == rbd_pkg::SUB_SYS_STATUS) begin
          ev.event_kind = rbd_pkg::EV_SYS_STATUS;
          ev.state_bit  = (packet_byte(3) & rbd_pkg::PWR_MASK) == rbd_pkg::PWR_ON;
        end
      end
      rbd_pkg::HDR_SENSOR: begin
        ev.event_kind = rbd_pkg::EV_SENSOR;
        ev.state_bit  = |(packet_byte(3) & rbd_pkg::SENSOR_ST_MASK);
        ev.address    = {2'b00, packet_byte(2), 6'b0} + 16'(packet_byte(3) >> 2);
      end
      rbd_pkg::HDR_LOGOUT: begin
        ev.event_kind = rbd_pkg::EV_LOGGED_OUT;
        ev.address    = {packet_byte(3), packet_byte(4)};
      end
      rbd_pkg::HDR_VEHICLE: begin
        if (packet_byte(2) == rbd_pkg::SUB_NOT_IN_USE) begin
          ev.event_kind = rbd_pkg::EV_NOT_IN_USE;
          ev.address    = {packet_byte(3), packet_byte(4)};
        end else if (packet_byte(2) == rbd_pkg::SUB_IN_USE) begin
          ev.event_kind = rbd_pkg::EV_IN_USE;
          ev.address    = {packet_byte(4), packet_byte(5)};
          ev.device_id  = packet_byte(6);
        end
      end
      default: ;
    endcase
    return ev;
  endfunction

  // Advance the framing by one byte; return 1 with the event when a packet
  // completes.
  function automatic logic deframe_byte(input logic [7:0] b, output rbd_pkg::event_t ev);
    logic [8:0] pos;
    ev = NO_EVENT;
    if (fr_phase == FR_IDLE) begin
      fr_head  = b;
      fr_count = 9'd1;
      if ((b & rbd_pkg::HDR_CLASS_MASK) == 8'h00) begin
        fr_total = 9'd3;
        fr_phase = FR_INFO_LEN;
      end else begin
        fr_total = 9'(b >> 5) + 9'd2;
        fr_phase = FR_BODY;
      end
      return 1'b0;
    end
    pos = fr_count;
    if (pos >= 1 && pos <= CAP_BYTES)
      fr_cap[pos - 1] = b;
    fr_count = fr_count + 9'd1;
    // the second byte after an info header carries the payload length
    if (fr_phase == FR_INFO_LEN && pos == 9'd2) begin
      fr_total = 9'd3 + 9'(b);
      fr_phase = FR_BODY;
    end
    if (fr_count >= fr_total) begin
      ev       = decode_packet();
      fr_phase = FR_IDLE;
      fr_count = 9'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one byte, hold it until the request is taken, then predict.
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input rbd_pkg::event_t typed_ev);
    rbd_pkg::event_t ev;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (deframe_byte(b, ev))
      pending_events.push_back(typed ? typed_ev : ev);
  endtask

  // Build one random packet, mostly well formed, sometimes loose bytes.
  task automatic build_packet();
    int         sel;
    int         len;
    logic [7:0] hdr;
    pkt_bytes.delete();
    sel = $urandom_range(99);
    if (sel < 14) begin
      pkt_bytes = '{rbd_pkg::HDR_INFO, 8'($urandom), rbd_pkg::SUB_SYS_STATUS, 8'($urandom)};
    end else if (sel < 26) begin
      // info packet with any low header; rarely a long payload
      hdr = 8'($urandom_range(0, 31));
      len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(8);
      pkt_bytes = '{hdr, 8'($urandom), 8'(len)};
      repeat (len) pkt_bytes.push_back(8'($urandom));
    end else if (sel < 42) begin
      pkt_bytes = '{rbd_pkg::HDR_SENSOR, 8'($urandom), 8'($urandom), 8'($urandom)};
    end else if (sel < 54) begin
      pkt_bytes = '{rbd_pkg::HDR_LOGOUT, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom)};
    end else if (sel < 76) begin
      case ($urandom_range(3))
        0, 1:    hdr = rbd_pkg::SUB_IN_USE;
        2:       hdr = rbd_pkg::SUB_NOT_IN_USE;
        default: hdr = 8'($urandom);
      endcase
      pkt_bytes = '{rbd_pkg::HDR_VEHICLE, 8'($urandom), hdr, 8'($urandom)};
    end else if (sel < 92) begin
      // command packet with any upper header
      hdr = 8'($urandom_range(32, 255));
      pkt_bytes.push_back(hdr);
      repeat (int'(hdr >> 5) + 1) pkt_bytes.push_back(8'($urandom));
    end else begin
      // loose bytes; framing simply follows the counts
      repeat ($urandom_range(1, 5)) pkt_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Compare one taken event against the oldest owed event.
  task automatic check_event();
    rbd_pkg::event_t want;
    if (pending_events.size() == 0) begin
      report_mismatch($sformatf("event kind %0d with no packet pending", out_ch.event_kind));
      return;
    end
    want = pending_events.pop_front();
    check_field("event_kind",  16'(out_ch.event_kind),  16'(want.event_kind));
    check_field("address",     out_ch.address,          want.address);
    check_field("state_bit",   16'(out_ch.state_bit),   16'(want.state_bit));
    check_field("device_id",   16'(out_ch.device_id),   16'(want.device_id));
    check_field("header_code", 16'(out_ch.header_code), 16'(want.header_code));
  endtask

  // Sample the event channel at the edge, then draw the next ready.
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_event();
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run once no request moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int send_pct  [4];
    int stall_pct [4];
    int sent;
    send_pct  = '{0, 54, 0, 29};
    stall_pct = '{0, 0, 54, 29};

    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    fr_phase       = FR_IDLE;
    fr_head        = 8'h00;
    fr_count       = 9'd0;
    fr_total       = 9'd0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed packets, no idling
    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].ev);

    // random packet streams, one idling pattern per phase
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = stall_pct[p];
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_packet();
        foreach (pkt_bytes[k])
          send_byte(pkt_bytes[k], 1'b0, NO_EVENT);
        sent += pkt_bytes.size();
      end
    end

    // drop valid, drain owed events, then hold for strays before the final check
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
    if (err_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
